@@ rtl/rfvq_pkg.sv @@
`default_nettype none
package rfvq_pkg;

    localparam int VALUE_W = 11;
    localparam int KW      = 3;

    typedef struct packed {
        logic         mode;
        logic [9:0]   position;
        logic [10:0]  item_value;
        logic [9:0]   range_start;
        logic [10:0]  range_end;
        logic [2:0]   divisor;
    } rfvq_in_t;

    typedef struct packed {
        logic         found;
        logic [10:0]  answer;
    } rfvq_out_t;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1
    } rfvq_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN1,
        ST_DRAIN1,
        ST_SCAN2,
        ST_DRAIN2,
        ST_PICK,
        ST_FINISH
    } rfvq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // write store from input beat
        logic init;      // latch query, clear summaries
        logic scan;      // read store at address, step address
        logic pass2;     // read belongs to counting pass
        logic rewind;    // address back to range start
        logic pick;      // evaluate one candidate slot
        logic emit;      // result into output register
    } rfvq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic query_ok;
        logic last_addr;
        logic last_slot;
        logic out_free;
    } rfvq_status_t;

endpackage
`default_nettype wire

@@ rtl/range_frequent_value_query.sv @@
`default_nettype none
// Channel  | Ports                     | Beat
// ---------+---------------------------+-----------------------------------------
// input    | s_valid, s_ready, s_data  | load (mode 0) or query (mode 1)
// result   | m_valid, m_ready, m_data  | found + answer, one per query beat
//
// A load writes the store and leaves the controller idle. A query sweeps its
// range twice over the single store read port, once to build a Misra-Gries
// summary in NS = MAX_DIVISOR-1 slots and once to count its candidates exactly,
// and an invalid query answers without a sweep. Reset (aresetn, synchronous)
// clears control only; store contents stay unknown until written.
// The result register holds a beat under m_ready stall; new beats are accepted
// while it is held, but a finished query waits for it with s_ready low.
module range_frequent_value_query
    import rfvq_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int MAX_DIVISOR = 5
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire rfvq_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rfvq_out_t     m_data
);

    rfvq_cmd_t    cmd;
    rfvq_status_t status;
    rfvq_out_t    result;
    logic         out_valid_reg;
    rfvq_out_t    out_data_reg;
    logic         out_free;

    // output register free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_ready;

    rfvq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_mode (s_data.mode),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    rfvq_dp #(
        .DEPTH       (DEPTH),
        .MAX_DIVISOR (MAX_DIVISOR)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cmd      (cmd),
        .out_free (out_free),
        .status   (status),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire

@@ rtl/rfvq_ctrl.sv @@
`default_nettype none
module rfvq_ctrl
    import rfvq_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic         in_mode,
    input  wire rfvq_status_t status,
    output logic              s_ready,
    output rfvq_cmd_t         cmd
);

    rfvq_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (in_mode == MODE_QUERY[0]) begin
                        cmd.init   = 1'b1;
                        state_next = ST_CHECK;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                state_next = status.query_ok ? ST_SCAN1 : ST_FINISH;
            end
            ST_SCAN1: begin
                cmd.scan = 1'b1;
                if (status.last_addr) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: begin
                cmd.rewind = 1'b1;
                state_next = ST_SCAN2;
            end
            ST_SCAN2: begin
                cmd.scan  = 1'b1;
                cmd.pass2 = 1'b1;
                if (status.last_addr) begin
                    state_next = ST_DRAIN2;
                end
            end
            ST_DRAIN2: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                cmd.pick = 1'b1;
                if (status.last_slot) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/rfvq_dp.sv @@
`default_nettype none
module rfvq_dp
    import rfvq_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int MAX_DIVISOR = 5
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire rfvq_in_t     s_data,
    input  wire rfvq_cmd_t    cmd,
    input  wire logic         out_free,
    output rfvq_status_t      status,
    output rfvq_out_t         result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NS = MAX_DIVISOR - 1;
    localparam int SW = (NS > 1) ? $clog2(NS) : 1;

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [9:0]          start_q_reg;
    logic [10:0]         end_q_reg;
    logic [KW-1:0]       k_q_reg;
    logic [CW-1:0]       addr_reg;
    logic [VALUE_W-1:0]  rd_reg;
    logic                dv_reg;
    logic                dpass_reg;
    logic [KW-1:0]       rem_reg;
    logic [CW-1:0]       thr_reg;
    logic [VALUE_W-1:0]  mg_val_reg [NS];
    logic [CW-1:0]       mg_cnt_reg [NS];
    logic [CW-1:0]       cnt2_reg   [NS];
    logic [VALUE_W-1:0]  mg_val_next [NS];
    logic [CW-1:0]       mg_cnt_next [NS];
    logic [SW-1:0]       idx_reg;
    logic                best_found_reg;
    logic [VALUE_W-1:0]  best_val_reg;

    logic [NS-1:0] act, hit, free, sel;
    logic          taken;

    // store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.load && (32'(s_data.position) < DEPTH)) begin
            mem[AW'(s_data.position)] <= s_data.item_value;
        end
        if (cmd.scan) begin
            rd_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
        end else begin
            dv_reg <= cmd.scan;
        end
        dpass_reg <= cmd.pass2;
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            start_q_reg <= s_data.range_start;
            end_q_reg   <= s_data.range_end;
            k_q_reg     <= s_data.divisor;
        end
        if (cmd.init) begin
            addr_reg <= CW'(s_data.range_start);
        end else if (cmd.rewind) begin
            addr_reg <= CW'(start_q_reg);
        end else if (cmd.scan) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    assign status.query_ok  = (32'(start_q_reg) < 32'(end_q_reg)) &&
                              (32'(end_q_reg) <= DEPTH) &&
                              (32'(k_q_reg) >= 2) && (32'(k_q_reg) <= MAX_DIVISOR);
    assign status.last_addr = (32'(addr_reg) + 1) == 32'(end_q_reg);
    assign status.last_slot = (idx_reg == SW'(NS - 1));
    assign status.out_free  = out_free;

    // Misra-Gries update over k-1 active slots
    always_comb begin
        taken = 1'b0;
        sel   = '0;
        for (int i = 0; i < NS; i++) begin
            act[i]  = (i + 2) <= 32'(k_q_reg);
            hit[i]  = act[i] && (mg_cnt_reg[i] != '0) && (mg_val_reg[i] == rd_reg);
            free[i] = act[i] && (mg_cnt_reg[i] == '0);
        end
        for (int i = 0; i < NS; i++) begin
            if (free[i] && !taken) begin
                sel[i] = 1'b1;
                taken  = 1'b1;
            end
        end
        for (int i = 0; i < NS; i++) begin
            mg_val_next[i] = mg_val_reg[i];
            mg_cnt_next[i] = mg_cnt_reg[i];
            if (|hit) begin
                if (hit[i]) begin
                    mg_cnt_next[i] = mg_cnt_reg[i] + 1'b1;
                end
            end else if (taken) begin
                if (sel[i]) begin
                    mg_val_next[i] = rd_reg;
                    mg_cnt_next[i] = CW'(1);
                end
            end else if (act[i]) begin
                mg_cnt_next[i] = mg_cnt_reg[i] - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            rem_reg <= '0;
            thr_reg <= '0;
            for (int i = 0; i < NS; i++) begin
                mg_cnt_reg[i] <= '0;
                cnt2_reg[i]   <= '0;
            end
        end else if (dv_reg && !dpass_reg) begin
            // floor(len/k) counted alongside the first pass
            if (rem_reg + 1'b1 == k_q_reg) begin
                rem_reg <= '0;
                thr_reg <= thr_reg + 1'b1;
            end else begin
                rem_reg <= rem_reg + 1'b1;
            end
            for (int i = 0; i < NS; i++) begin
                mg_val_reg[i] <= mg_val_next[i];
                mg_cnt_reg[i] <= mg_cnt_next[i];
            end
        end else if (dv_reg && dpass_reg) begin
            for (int i = 0; i < NS; i++) begin
                if (act[i] && (mg_cnt_reg[i] != '0) && (mg_val_reg[i] == rd_reg)) begin
                    cnt2_reg[i] <= cnt2_reg[i] + 1'b1;
                end
            end
        end
    end

    // candidate pick, one slot a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            best_val_reg   <= '0;
        end else if (cmd.init) begin
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            best_val_reg   <= '0;
        end else if (cmd.pick) begin
            idx_reg <= idx_reg + 1'b1;
            if (act[idx_reg] && (mg_cnt_reg[idx_reg] != '0) &&
                (cnt2_reg[idx_reg] > thr_reg) &&
                (!best_found_reg || (mg_val_reg[idx_reg] < best_val_reg))) begin
                best_found_reg <= 1'b1;
                best_val_reg   <= mg_val_reg[idx_reg];
            end
        end
    end

    assign result.found  = best_found_reg;
    assign result.answer = best_val_reg;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfvq_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int MAX_DIVISOR = 5;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 64;
    localparam int FILL_TOP    = 256;   // positions 0..FILL_TOP-1 written first
    localparam int HOLD_CYCLES = 3000;

    // Expected-answer store with its own copy of the value array.
    class answer_board;
        logic [10:0] shadow [DEPTH];
        rfvq_out_t   pending [$];
        int          errors;
        int          checked;
        int          found_seen;

        function new();
            errors     = 0;
            checked    = 0;
            found_seen = 0;
        endfunction

        // work out the answer of one query against the shadow store
        function rfvq_out_t frequent_value(rfvq_in_t q);
            rfvq_out_t   r;
            int unsigned len;
            int unsigned threshold;
            int unsigned counts [2048];
            r = '0;
            if (q.range_start >= q.range_end || q.range_end > DEPTH) return r;
            if (q.divisor < 2 || q.divisor > MAX_DIVISOR) return r;
            len       = q.range_end - q.range_start;
            threshold = len / q.divisor;
            foreach (counts[v]) counts[v] = 0;
            for (int i = q.range_start; i < q.range_end; i++)
                counts[shadow[i]]++;
            for (int v = 0; v < 2048; v++) begin
                if (counts[v] > threshold) begin
                    r.found  = 1'b1;
                    r.answer = v[10:0];
                    break;
                end
            end
            return r;
        endfunction

        function void note_input(rfvq_in_t b);
            if (b.mode == MODE_LOAD[0]) begin
                shadow[b.position] = b.item_value;
            end else begin
                pending = {pending, frequent_value(b)};
            end
        endfunction

        function void check_result(rfvq_out_t got);
            rfvq_out_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat found=%0d answer=%0d",
                         $time, got.found, got.answer);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.found) found_seen++;
            if (got.found !== exp.found) begin
                $display("%0t: found expected %0d actual %0d", $time, exp.found, got.found);
                errors++;
            end
            if (got.answer !== exp.answer) begin
                $display("%0t: answer expected %0d actual %0d",
                         $time, exp.answer, got.answer);
                errors++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rfvq_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rfvq_out_t m_data;

    answer_board board = new();
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;      // long receiver stall requested
    bit  hold_done = 1'b0;     // long stall has run its course
    int  hold_cnt = 0;
    int  loads_sent = 0;
    int  queries_sent = 0;

    always #4 aclk = ~aclk;

    range_frequent_value_query #(
        .DEPTH(DEPTH),
        .MAX_DIVISOR(MAX_DIVISOR)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // monitor: sample both channels on the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_input(s_data);
            if (m_valid && m_ready) board.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off && !hold_done) begin
            m_ready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            case ($urandom_range(0, 3))
                0:       m_ready <= 1'b0;
                1:       m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // offer one beat and wait for its handshake; valid is dropped by the caller
    task automatic send_beat(rfvq_in_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_load(int pos, int val);
        rfvq_in_t b;
        b             = rfvq_in_t'($urandom());
        b.mode        = MODE_LOAD[0];
        b.position    = pos[9:0];
        b.item_value  = val[10:0];
        send_beat(b);
        loads_sent++;
    endtask

    task automatic send_query(int st, int en, int k);
        rfvq_in_t b;
        b             = rfvq_in_t'($urandom());
        b.mode        = MODE_QUERY[0];
        b.range_start = st[9:0];
        b.range_end   = en[10:0];
        b.divisor     = k[2:0];
        send_beat(b);
        queries_sent++;
    endtask

    // random gap between bursts
    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // a range inside the written prefix, mostly short; some queries are malformed
    task automatic rand_query();
        int st, en, k, len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, FILL_TOP)
                                           : $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0) begin
            // malformed: reversed, empty, past the end, or bad divisor
            case ($urandom_range(0, 3))
                0: begin st = $urandom_range(1, 1023); en = $urandom_range(0, st); end
                1: begin st = $urandom_range(0, 1023); en = $urandom_range(1025, 2047); end
                2: begin st = 0; en = 0; end
                default: begin st = 0; en = 4; end
            endcase
            k = ($urandom_range(0, 1)) ? $urandom_range(0, 1) : $urandom_range(6, 7);
            if (st < en && en <= DEPTH && $urandom_range(0, 1)) k = $urandom_range(2, 5);
        end else begin
            st = $urandom_range(0, FILL_TOP - len);
            en = st + len;
            k  = $urandom_range(2, MAX_DIVISOR);
        end
        send_query(st, en, k);
    endtask

    initial begin
        int burst;
        int items;
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // prefix and last entry written first: queries stay on written entries.
        // small value alphabet so that majorities occur; values 1 and 1024 included.
        for (int p = 0; p < FILL_TOP; p++) begin
            case ($urandom_range(0, 9))
                0:       send_load(p, 1024);
                1:       send_load(p, 1);
                2:       send_load(p, $urandom_range(1, 1024));
                default: send_load(p, $urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 31) == 0) sender_gap();
        end
        send_load(DEPTH - 1, 1024);

        // directed: extremes of range and divisor, invalid forms, a stored 0
        send_query(0, FILL_TOP, 2);
        send_query(0, FILL_TOP, MAX_DIVISOR);
        send_query(1023, 1024, 2);
        send_query(0, 1, 3);
        send_query(5, 5, 2);
        send_query(10, 3, 2);
        send_query(0, 1025, 2);
        send_query(1023, 2047, 4);
        send_query(0, 8, 0);
        send_query(0, 8, 1);
        send_query(0, 8, 6);
        send_query(0, 8, 7);
        for (int p = 0; p < 6; p++) send_load(100 + p, 7);
        send_query(100, 106, 2);
        send_load(200, 0);
        send_load(201, 0);
        send_load(202, 2047);
        send_query(200, 202, 2);
        send_query(200, 203, 3);
        send_load(0, 1024);
        send_query(0, 2, 2);
        send_query(98, 110, 5);

        // receiver holds off while the sender keeps offering queries
        hold_off = 1'b1;
        for (int n = 0; n < 12; n++) send_query(n * 4, n * 4 + 8, 2);

        // random part: bursts of mixed loads and queries
        items = 0;
        while (items < 260) begin
            burst = $urandom_range(1, 16);
            for (int n = 0; n < burst; n++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_load($urandom_range(0, 1023),
                              $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                        : $urandom_range(1, 3));
                end else begin
                    rand_query();
                end
                items++;
            end
            sender_gap();
        end
        s_valid <= 1'b0;

        fork
            begin
                while (board.pending.size() != 0) @(posedge aclk);
                repeat (TAIL_CYCLES) @(posedge aclk);
            end
            begin
                repeat (200 * STALL_LIMIT) @(posedge aclk);
                $display("%0t: drain timeout", $time);
                board.errors++;
            end
        join_any
        disable fork;

        $display("%0d loads, %0d queries sent; %0d results checked, %0d with a value found",
                 loads_sent, queries_sent, board.checked, board.found_seen);
        $display("ranges across the written prefix and last entry, bad divisors, long stall");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
